// ===== rtl/sapq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_pkg
// Types, codes and sizes shared by the sorted array priority store.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int OPCODE_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int FIDX_W    = 4;
    localparam int KEYF_W    = 32;
    localparam int COUNTF_W  = 5;

    typedef logic [KEY_WIDTH-1:0] t_key;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_DEL_MIN = 3'd1,
        OP_DEL_MAX = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic del_min;
        t_key key;
    } t_cell_ctl;

endpackage

// ===== rtl/sapq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq request and response interfaces
// Valid/ready channels carrying the operation request and its result.
// ----------------------------------------------------------------------------
interface sapq_req_if;
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic [31:0]         key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface sapq_rsp_if;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [3:0]          found_index;
    logic [31:0]         min_key;
    logic [31:0]         max_key;
    logic [4:0]          count;
    logic                is_empty;

    modport source (output valid, output status, output found_index, output min_key,
                    output max_key, output count, output is_empty, input ready);
    modport sink   (input valid, input status, input found_index, input min_key,
                    input max_key, input count, input is_empty, output ready);
endinterface

// ===== rtl/sapq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted row: holds a key, compares it with the broadcast
// key and takes its new value from itself, a neighbour or the broadcast key.
// ----------------------------------------------------------------------------
module sapq_cell
    import sapq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  logic      i_at_end,
    input  t_key      i_prev_key,
    input  logic      i_prev_gt,
    input  t_key      i_next_key,
    output t_key      o_key,
    output logic      o_gt,
    output logic      o_match
);

    t_key r_key;
    t_key n_key;

    assign o_key   = r_key;
    assign o_gt    = i_occ && (r_key > i_ctl.key);
    assign o_match = i_occ && (r_key == i_ctl.key);

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && (o_gt || i_at_end)) begin
            // larger keys move up one slot, the new key lands after equal ones
            n_key = i_prev_gt ? i_prev_key : i_ctl.key;
        end else if (i_ctl.del_min) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== rtl/sorted_array_priority_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_priority_store_core
// Sorted priority store built as a row of key cells.
// ----------------------------------------------------------------------------
// Usage:
//  i_req carries an opcode (insert, delete smallest, delete largest, search,
//  clear) and a key; o_rsp returns one result per request: status, found
//  index, smallest and largest key, count and empty flag, all after the
//  operation.
//  A request is applied to every cell of the row in the cycle it is taken;
//  the result is formed from the updated row in the next cycle and held in
//  an output register; i_req.ready stays low until that result is loaded,
//  so a new request waits until the last one has reached that register.
//  A new request is taken while an earlier result still waits in the output
//  register; if the receiver stalls, the following request is held until the
//  output register frees, and i_req.ready stays low meanwhile.
//  Reset empties the store (count to zero) and drops any pending result; the
//  key cells themselves need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_array_priority_store_core
    import sapq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sapq_req_if.sink    i_req,
    sapq_rsp_if.source  o_rsp
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_busy;
    t_status           r_status;
    t_status           n_status;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [FIDX_W-1:0] r_out_idx;
    logic [KEYF_W-1:0] r_out_min;
    logic [KEYF_W-1:0] r_out_max;
    logic [COUNTF_W-1:0] r_out_count;
    logic              r_out_empty;

    t_cell_ctl         w_ctl;
    t_op               w_op;
    t_key              w_k;
    logic [63:0]       w_key_ext;
    logic              w_fire;
    logic              w_full;
    logic              w_empty;
    logic              w_load;
    logic              w_found;
    logic [IDX_W-1:0]  w_first_idx;
    t_key              w_max;
    t_key              w_min;
    logic [63:0]       w_min_ext;
    logic [63:0]       w_max_ext;
    logic [15:0]       w_idx_ext;
    logic [15:0]       w_cnt_ext;

    t_key              w_key   [DEPTH];
    logic              w_gt    [DEPTH];
    logic              w_match [DEPTH];

    assign i_req.ready = !r_busy;
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_op        = t_op'(i_req.opcode);
    assign w_key_ext   = 64'(i_req.key);
    assign w_k         = w_key_ext[KEY_WIDTH-1:0];
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sapq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (CNT_W'(g) < r_count),
            .i_at_end   (CNT_W'(g) == r_count),
            .i_prev_key ((g == 0) ? t_key'(0) : w_key[(g == 0) ? 0 : g - 1]),
            .i_prev_gt  ((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
            .i_next_key (w_key[(g == DEPTH - 1) ? g : g + 1]),
            .o_key      (w_key[g]),
            .o_gt       (w_gt[g]),
            .o_match    (w_match[g])
        );
    end

    // matches are contiguous in a sorted row, so the first one is unique
    always_comb begin
        w_found     = 1'b0;
        w_first_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i] && ((i == 0) || !w_match[(i == 0) ? 0 : i - 1])) begin
                w_found     = 1'b1;
                w_first_idx = w_first_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        w_ctl.key     = w_k;
        w_ctl.ins     = 1'b0;
        w_ctl.del_min = 1'b0;
        n_count       = r_count;
        n_status      = ST_OK;
        n_idx         = '0;
        unique case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_fire;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_DEL_MIN: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.del_min = w_fire;
                    n_count       = r_count - 1'b1;
                end
            end
            OP_DEL_MAX: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_SEARCH: begin
                if (w_found) begin
                    n_idx = w_first_idx;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
                r_busy  <= 1'b1;
            end else if (w_load) begin
                r_busy  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_idx    <= n_idx;
        end
    end

    // result from the updated row: top occupied cell holds the largest key
    always_comb begin
        w_max = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i + 1) == r_count) begin
                w_max = w_max | w_key[i];
            end
        end
        w_min = (r_count == '0) ? t_key'(0) : w_key[0];
    end

    assign w_min_ext = 64'(w_min);
    assign w_max_ext = 64'(w_max);
    assign w_idx_ext = 16'(r_idx);
    assign w_cnt_ext = 16'(r_count);
    assign w_load    = r_busy && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_idx    <= w_idx_ext[FIDX_W-1:0];
            r_out_min    <= w_min_ext[KEYF_W-1:0];
            r_out_max    <= w_max_ext[KEYF_W-1:0];
            r_out_count  <= w_cnt_ext[COUNTF_W-1:0];
            r_out_empty  <= (r_count == '0);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_index = r_out_idx;
    assign o_rsp.min_key     = r_out_min;
    assign o_rsp.max_key     = r_out_max;
    assign o_rsp.count       = r_out_count;
    assign o_rsp.is_empty    = r_out_empty;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_op == OP_INSERT) && !w_full) |=>
        (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the store");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_empty == (r_out_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> ((r_out_min == '0) && (r_out_max == '0)))
        else $error("keys reported while empty");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_count != '0)) |-> (w_min <= w_max))
        else $error("row out of order");

endmodule

// ===== test/tb_sorted_array_priority_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_store_core
// Self-checking bench for the sorted priority store. A scoreboard class keeps
// its own sorted copy of the keys, predicts every result when a request is
// taken, and compares each result field by field. Stimulus is a short
// directed sequence followed by random fill, drain, mixed and back-pressure
// phases, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_store_core;
    import sapq_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 11;
    localparam int RANDOM_REQUESTS   = 500;
    localparam int LONG_STALL_CYCLES = 150;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int OPCODE_MAX        = 7;

    typedef logic [OPCODE_W-1:0] t_opcode;

    typedef struct packed {
        t_status               status;
        logic [FIDX_W-1:0]     found_index;
        t_key                  min_key;
        t_key                  max_key;
        logic [COUNTF_W-1:0]   count;
        logic                  is_empty;
    } t_store_result;

    class sorted_store_scoreboard;
        t_key          keys[DEPTH];
        int unsigned   fill          = 0;
        t_store_result awaited[$];
        int unsigned   mismatches    = 0;
        int unsigned   requests      = 0;
        int unsigned   results_seen  = 0;
        int unsigned   full_drops    = 0;
        int unsigned   empty_deletes = 0;
        int unsigned   search_hits   = 0;
        int unsigned   search_misses = 0;
        int unsigned   spare_ops     = 0;
        int unsigned   peak_fill     = 0;

        // apply one taken request to the local copy and queue its result
        function void note_request(t_opcode op, t_key key);
            t_store_result exp;
            int unsigned   pos;
            exp.status      = ST_OK;
            exp.found_index = '0;
            requests++;
            case (op)
                OP_INSERT: begin
                    if (fill >= DEPTH) begin
                        exp.status = ST_FULL;
                        full_drops++;
                    end else begin
                        // equal keys stay ahead of the new one
                        pos = fill;
                        while (pos > 0 && keys[pos-1] > key) begin
                            keys[pos] = keys[pos-1];
                            pos--;
                        end
                        keys[pos] = key;
                        fill++;
                    end
                end
                OP_DEL_MIN, OP_DEL_MAX: begin
                    if (fill == 0) begin
                        exp.status = ST_EMPTY;
                        empty_deletes++;
                    end else begin
                        if (op == OP_DEL_MIN)
                            for (int i = 0; i + 1 < fill; i++) keys[i] = keys[i+1];
                        fill--;
                    end
                end
                OP_SEARCH: begin
                    exp.status = ST_NOT_FOUND;
                    for (int i = 0; i < fill; i++) begin
                        if (keys[i] == key) begin
                            exp.status      = ST_OK;
                            exp.found_index = FIDX_W'(i);
                            break;
                        end
                    end
                    if (exp.status == ST_OK) search_hits++;
                    else search_misses++;
                end
                OP_CLEAR: fill = 0;
                default: spare_ops++;
            endcase
            exp.min_key  = (fill == 0) ? '0 : keys[0];
            exp.max_key  = (fill == 0) ? '0 : keys[fill-1];
            exp.count    = COUNTF_W'(fill);
            exp.is_empty = (fill == 0);
            if (fill > peak_fill) peak_fill = fill;
            awaited.push_back(exp);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: mismatch on %s, expected %h, actual %h",
                         $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_store_result got);
            t_store_result exp;
            results_seen++;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing awaited, actual %h", $time, got);
                mismatches++;
                return;
            end
            exp = awaited.pop_front();
            compare_field("status",      32'(exp.status),      32'(got.status));
            compare_field("found_index", 32'(exp.found_index), 32'(got.found_index));
            compare_field("min_key",     exp.min_key,          got.min_key);
            compare_field("max_key",     exp.max_key,          got.max_key);
            compare_field("count",       32'(exp.count),       32'(got.count));
            compare_field("is_empty",    32'(exp.is_empty),    32'(got.is_empty));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sapq_req_if req_bus ();
    sapq_rsp_if rsp_bus ();

    sorted_array_priority_store_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    sorted_store_scoreboard sb = new();

    int unsigned burst_left       = 0;
    bit          gapless          = 1'b0;
    int unsigned long_stall_asks  = 0;
    int unsigned long_stall_done  = 0;
    int unsigned idle_cycles      = 0;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------- sender

    task automatic offer_request(input t_opcode op, input t_key key);
        if (!gapless) begin
            if (burst_left == 0) begin
                req_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
        end
        req_bus.valid  <= 1'b1;
        req_bus.opcode <= op;
        req_bus.key    <= key;
        do @(posedge clk); while (!req_bus.ready);
        sb.note_request(op, key);
        @(negedge clk);
    endtask

    function automatic t_key pick_key();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 7);
            1:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    // mostly keys that are stored, so searches hit and duplicates show up
    function automatic t_key pick_search_key();
        if (sb.fill > 0 && $urandom_range(0, 2) != 0)
            return sb.keys[$urandom_range(0, sb.fill - 1)];
        return pick_key();
    endfunction

    function automatic t_opcode pick_delete();
        return ($urandom_range(0, 1) == 1) ? OP_DEL_MIN : OP_DEL_MAX;
    endfunction

    task automatic random_request(input int unsigned insert_pct, input int unsigned delete_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            offer_request(OP_INSERT, pick_key());
        else if (roll < insert_pct + delete_pct)
            offer_request(pick_delete(), $urandom());
        else if (roll < 96)
            offer_request(OP_SEARCH, pick_search_key());
        else if (roll < 98)
            offer_request(OP_CLEAR, $urandom());
        else
            offer_request(t_opcode'($urandom_range(OP_CLEAR + 1, OPCODE_MAX)), $urandom());
    endtask

    // receiver holds off while the sender keeps the requests coming
    task automatic pressure_phase();
        long_stall_asks++;
        gapless = 1'b1;
        repeat ($urandom_range(8, 16)) random_request(45, 30);
        gapless = 1'b0;
    endtask

    initial begin
        int unsigned first_random;
        rst_n          = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.opcode = OP_INSERT;
        req_bus.key    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store, extremes, duplicates, spare opcodes
        offer_request(OP_DEL_MIN, '0);
        offer_request(OP_DEL_MAX, '1);
        offer_request(OP_SEARCH, '0);
        offer_request(OP_INSERT, 32'hFFFF_FFFF);
        offer_request(OP_INSERT, 32'h0000_0000);
        offer_request(OP_INSERT, 32'd5);
        offer_request(OP_INSERT, 32'd5);
        offer_request(OP_INSERT, 32'd5);
        offer_request(OP_SEARCH, 32'd5);
        offer_request(OP_SEARCH, 32'd6);
        offer_request(OP_SEARCH, 32'hFFFF_FFFF);
        offer_request(OP_SEARCH, 32'd0);
        for (int op = OP_CLEAR + 1; op <= OPCODE_MAX; op++)
            offer_request(t_opcode'(op), 32'hA5A5_5A5A);
        offer_request(OP_DEL_MAX, '0);
        offer_request(OP_DEL_MIN, '0);
        offer_request(OP_CLEAR, '1);
        offer_request(OP_SEARCH, 32'd5);
        offer_request(OP_INSERT, 32'h8000_0000);
        offer_request(OP_INSERT, 32'h7FFF_FFFF);
        offer_request(OP_DEL_MIN, '0);
        offer_request(OP_DEL_MAX, '0);
        offer_request(OP_DEL_MAX, '0);

        first_random = sb.requests;
        pressure_phase();
        while (sb.requests - first_random < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 4))
                0: begin
                    while (sb.fill < DEPTH) random_request(85, 5);
                    repeat ($urandom_range(1, 3)) offer_request(OP_INSERT, pick_key());
                end
                1: begin
                    while (sb.fill > 0) random_request(5, 80);
                    repeat ($urandom_range(1, 3)) offer_request(pick_delete(), $urandom());
                end
                2: pressure_phase();
                default: repeat ($urandom_range(10, 30)) random_request(40, 35);
            endcase
        end

        req_bus.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results, peak fill %0d of %0d",
                 sb.requests, sb.results_seen, sb.peak_fill, DEPTH);
        $display("full drops %0d, empty deletes %0d, search hits %0d misses %0d, spare %0d",
                 sb.full_drops, sb.empty_deletes, sb.search_hits, sb.search_misses,
                 sb.spare_ops);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("tb_sorted_array_priority_store_core OK");
        end else begin
            $display("tb_sorted_array_priority_store_core NOT OK");
        end
        $finish;
    end

    // -------------------------------------------------------------- receiver

    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        rsp_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_stall_done != long_stall_asks) begin
                long_stall_done++;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       rsp_bus.ready <= 1'b1;
                    1:       rsp_bus.ready <= $urandom_range(0, 1);
                    2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_bus.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------ monitor, watchdog

    always @(posedge clk) begin
        t_store_result got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got.status      = t_status'(rsp_bus.status);
            got.found_index = rsp_bus.found_index;
            got.min_key     = rsp_bus.min_key;
            got.max_key     = rsp_bus.max_key;
            got.count       = rsp_bus.count;
            got.is_empty    = rsp_bus.is_empty;
            sb.check_result(got);
        end
    end

    always @(posedge clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles, %0d results awaited",
                     $time, idle_cycles, sb.awaited.size());
            $display("tb_sorted_array_priority_store_core NOT OK");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/sapq_pkg.sv
rtl/sapq_if.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_store_core.sv
test/tb_sorted_array_priority_store_core.sv
